[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check property p on every rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, p, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);

// Check that a implies b in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

[hdl/hsff_pkg.sv]
package hsff_pkg;
  localparam int unsigned NumStatesDef  = 8;
  localparam int unsigned NumSymbolsDef = 16;
  localparam int unsigned FracBitsDef   = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned RowW    = 3;
  localparam int unsigned ColW    = 4;
  localparam int unsigned ValueW  = 17;
  localparam int unsigned SymbolW = 4;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD_TRANS = 2'd0,
    KIND_LOAD_EMIT  = 2'd1,
    KIND_START      = 2'd2,
    KIND_SYMBOL     = 2'd3
  } kind_e;

  // Sequencer commands broadcast to every cell.
  typedef struct packed {
    logic mac;      // accumulate shifted-in alpha * transition
    logic trunc;    // truncate accumulator by the fraction width
    logic emit;     // multiply by emission value
    logic load_div; // capture scaled numerator for the divider
    logic div_step; // one restoring division step
    logic zero;     // clear result (zero scale)
    logic start;    // reset alpha to state 0 one
    logic commit;   // write quotient back to alpha
  } cell_cmd_t;
endpackage

[hdl/hsff_cell.sv]
module hsff_cell
  import hsff_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned SumW     = 24,
  parameter bit          IsFirst  = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_cmd_t           cmd_i,
  input  logic [FracBits:0]   alpha_i,     // from neighbor in the ring
  input  logic [FracBits:0]   trans_i,     // transition[src][this]
  input  logic [FracBits:0]   emit_i,
  input  logic [SumW-1:0]     sum_i,       // divisor
  output logic [FracBits:0]   alpha_o,     // ring value (own alpha outside mac), to neighbor
  output logic [SumW-1:0]     raw_o,
  output logic [FracBits:0]   prob_o
);
  localparam int unsigned PW   = FracBits + 1;
  localparam int unsigned AccW = 2 * PW + 6;
  localparam int unsigned NumW = SumW + FracBits + 1;

  logic [PW-1:0]   alpha_q, alpha_d, ring_q;
  logic [AccW-1:0] acc_q, acc_d;
  logic [NumW-1:0] num_q, num_d;
  logic [SumW:0]   rem_q, rem_d;
  logic [SumW:0]   trial;
  logic [NumW-1:0] quo_q, quo_d;

  always_comb begin
    alpha_d = alpha_q;
    acc_d   = acc_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    trial   = {rem_q[SumW-1:0], num_q[NumW-1]} - {1'b0, sum_i};
    if (cmd_i.start) begin
      alpha_d = IsFirst ? PW'(1 << FracBits) : '0;
    end else if (cmd_i.commit) begin
      alpha_d = (quo_q > NumW'(1 << FracBits)) ? PW'(1 << FracBits) : quo_q[PW-1:0];
    end
    if (cmd_i.mac) begin
      acc_d = acc_q + AccW'(ring_q * trans_i);
    end else if (cmd_i.trunc) begin
      acc_d = acc_q >> FracBits;
    end else if (cmd_i.emit) begin
      acc_d = AccW'((acc_q * emit_i) >> FracBits);
    end
    if (cmd_i.load_div) begin
      num_d = NumW'(acc_q) << FracBits;
      rem_d = '0;
      quo_d = '0;
    end else if (cmd_i.div_step) begin
      num_d = num_q << 1;
      if (!trial[SumW]) begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[SumW-1:0], num_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end else if (cmd_i.zero) begin
      quo_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= IsFirst ? PW'(1 << FracBits) : '0;
    end else begin
      alpha_q <= alpha_d;
    end
  end

  // Ring register: load own alpha, then rotate the neighbor's value each mac.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div || cmd_i.start || cmd_i.commit || !cmd_i.mac) ring_q <= alpha_d;
    else ring_q <= alpha_i;
    acc_q <= (cmd_i.load_div) ? '0 : acc_d;
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign alpha_o = ring_q;
  assign raw_o   = SumW'(acc_q);
  assign prob_o  = (quo_q > NumW'(1 << FracBits)) ? PW'(1 << FracBits) : quo_q[PW-1:0];
endmodule

[hdl/hmm_scaled_forward_filter_core.sv]
// Scaled forward filter of a discrete HMM. Kinds 0/1 write one transition or
// emission entry (saturated to one); kind 2 resets the forward vector; both
// return nothing. A symbol request runs over a ring of NUM_STATES cells, one
// per state: the vector rotates through the ring while each cell accumulates
// alpha*transition (the transition memory is banked by destination), then
// each cell truncates and multiplies by the emission value, the raw values
// are summed serially, then a load step and FRAC_BITS+SumW+1 restoring division
// steps (none for a zero sum) run in every cell in parallel; NUM_STATES
// results then drain at one per cycle while the output is not stalled.
// Tables are undefined until written. Input stall is high while busy.
`include "assert_macros.svh"
module hmm_scaled_forward_filter_core
  import hsff_pkg::*;
#(
  parameter int unsigned NUM_STATES  = NumStatesDef,
  parameter int unsigned NUM_SYMBOLS = NumSymbolsDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  localparam int unsigned SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1,
  localparam int unsigned YW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1,
  localparam int unsigned CLW = (SW > YW) ? SW : YW,
  localparam int unsigned PW  = FRAC_BITS + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [SW-1:0]       row_i,
  input  logic [CLW-1:0]      col_i,
  input  logic [PW-1:0]       value_i,
  input  logic [YW-1:0]       symbol_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SW-1:0]       state_index_o,
  output logic [PW-1:0]       probability_o,
  output logic [PW-1:0]       scale_o,
  output logic                zero_scale_o,
  output logic                last_o
);
  localparam int unsigned N    = NUM_STATES;
  localparam int unsigned SumW = PW + SW + 1;
  localparam int unsigned DivSteps = SumW + FRAC_BITS + 1;
  localparam int unsigned CW   = $clog2(DivSteps + N + 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MAC   = 8'b0000_0010,
    ST_TRUNC = 8'b0000_0100,
    ST_EMIT  = 8'b0000_1000,
    ST_SUM   = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_LOAD  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [YW-1:0] sym_q;
  logic sym_bad_q;
  cell_cmd_t cmd;
  logic accept;

  logic [PW-1:0]   trans_mem [N][N];   // bank per destination, addressed by source
  logic [PW-1:0]   emit_mem  [N][NUM_SYMBOLS];
  logic [PW-1:0]   trans_rd [N];
  logic [PW-1:0]   emit_rd  [N];
  logic [PW-1:0]   alpha_w [N];
  logic [SumW-1:0] raw_w [N];
  logic [PW-1:0]   prob_w [N];
  logic [PW-1:0]   val_sat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign val_sat    = (value_i > PW'(1 << FRAC_BITS)) ? PW'(1 << FRAC_BITS) : value_i;

  // Table writes; reads registered. Source index for MAC rotates with cnt.
  always_ff @(posedge clk_i) begin
    if (accept && kind_e'(kind_i) == KIND_LOAD_TRANS && 32'(row_i) < N && 32'(col_i) < N)
      trans_mem[SW'(col_i)][row_i] <= val_sat;
    if (accept && kind_e'(kind_i) == KIND_LOAD_EMIT && 32'(row_i) < N &&
        32'(col_i) < NUM_SYMBOLS)
      emit_mem[row_i][YW'(col_i)] <= val_sat;
  end

  // Cell c sees at mac step k the alpha of state (c+k) mod N.
  for (genvar c = 0; c < N; c++) begin : g_rd
    logic [SW:0] src;
    assign src = (SW+1)'(c) + (SW+1)'(cnt_d);
    always_ff @(posedge clk_i) begin
      trans_rd[c] <= trans_mem[c][(src >= (SW+1)'(N)) ? SW'(src - (SW+1)'(N)) : SW'(src)];
      emit_rd[c]  <= sym_bad_q ? '0 : emit_mem[c][sym_q];
    end
  end

  for (genvar c = 0; c < N; c++) begin : g_cell
    hsff_cell #(.FracBits(FRAC_BITS), .SumW(SumW), .IsFirst(c == 0)) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd),
      .alpha_i(alpha_w[(c + 1) % N]), .trans_i(trans_rd[c]), .emit_i(emit_rd[c]),
      .sum_i(sum_q), .alpha_o(alpha_w[c]), .raw_o(raw_w[c]), .prob_o(prob_w[c]));
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && kind_e'(kind_i) == KIND_START) cmd.start = 1'b1;
        if (accept && kind_e'(kind_i) == KIND_SYMBOL) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // first transition reads settle; clear accumulators
        cmd.load_div = 1'b1;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          state_d = ST_TRUNC;
        end
      end
      ST_TRUNC: begin
        cmd.trunc = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cnt_d = '0;
        sum_d = '0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        sum_d = sum_q + raw_w[SW'(cnt_q)];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          cnt_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) cmd.load_div = 1'b1;
        else cmd.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (sum_q == '0) begin
          cmd.zero = 1'b1;
          cnt_d = '0;
          state_d = ST_DRAIN;
        end else if (cnt_q == CW'(DivSteps)) begin
          cmd.commit = 1'b0;
          cnt_d = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cnt_q == '0 && !out_stall_i) cmd.commit = 1'b0;
        if (!out_stall_i) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CW'(N - 1)) begin
            cmd.commit = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (accept) begin
      sym_q     <= symbol_i;
      sym_bad_q <= 32'(symbol_i) >= NUM_SYMBOLS;
    end
  end

  // Zero scale: cells clear quotient; commit then writes zeros into alpha.
  assign out_valid_o   = (state_q == ST_DRAIN);
  assign state_index_o = SW'(cnt_q);
  assign probability_o = prob_w[SW'(cnt_q)];
  assign scale_o       = (sum_q > SumW'(1 << FRAC_BITS)) ? PW'(1 << FRAC_BITS)
                                                         : PW'(sum_q);
  assign zero_scale_o  = (sum_q == '0);
  assign last_o        = (cnt_q == CW'(N - 1));

  `ASSERT_CLK(a_stall_busy, clk_i, rst_ni, (state_q != ST_IDLE) == in_stall_o, "stall mismatch")
  `ASSERT_NEXT(a_drain_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "drain dropped")
  `ASSERT_CLK(a_idx_range, clk_i, rst_ni, !out_valid_o || (cnt_q < CW'(N)), "index overrun")
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb
  import hsff_pkg::*;
();

  localparam int unsigned NS = NumStatesDef;
  localparam int unsigned NY = NumSymbolsDef;
  localparam int unsigned FB = FracBitsDef;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [RowW-1:0]   state_index;
    logic [ValueW-1:0] probability;
    logic [ValueW-1:0] scale;
    logic              zero_scale;
    logic              last;
  } filt_res_t;

  typedef struct {
    kind_e               kind;
    logic [RowW-1:0]     row;
    logic [ColW-1:0]     col;
    logic [ValueW-1:0]   value;
    logic [SymbolW-1:0]  symbol;
    bit                  typed;    // scale and zero flag known up front
    logic [ValueW-1:0]   t_scale;
    logic                t_zero;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KindW-1:0] kind = '0;
  logic [RowW-1:0] row = '0;
  logic [ColW-1:0] col = '0;
  logic [ValueW-1:0] value = '0;
  logic [SymbolW-1:0] symbol = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RowW-1:0] state_index;
  logic [ValueW-1:0] probability;
  logic [ValueW-1:0] scale;
  logic zero_scale;
  logic last;

  // Predictor state: Q1.16 tables and the forward vector.
  longint unsigned trans_tab [NS*NS];
  longint unsigned emit_tab [NS*NY];
  longint unsigned alpha [NS];
  filt_res_t pending_filt [$];

  int mismatches = 0;
  int cycles = 0;
  int out_wait = 0;
  bit out_burst = 1'b0;
  bit in_burst = 1'b0;
  request_t directed [$];

  hmm_scaled_forward_filter_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .row_i(row), .col_i(col), .value_i(value), .symbol_i(symbol),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .state_index_o(state_index), .probability_o(probability), .scale_o(scale),
    .zero_scale_o(zero_scale), .last_o(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one accepted request to the predictor; queue the per-state results.
  function automatic void filter_step(request_t r);
    longint unsigned raw [NS];
    longint unsigned sum, acc, v, p;
    filt_res_t e;
    v = (r.value > ONE) ? ONE : 64'(r.value);
    case (r.kind)
      KIND_LOAD_TRANS: if (r.col < NS) trans_tab[r.row*NS + r.col] = v;
      KIND_LOAD_EMIT:  if (r.col < NY) emit_tab[r.row*NY + r.col] = v;
      KIND_START: begin
        foreach (alpha[i]) alpha[i] = 0;
        alpha[0] = ONE;
      end
      KIND_SYMBOL: begin
        sum = 0;
        for (int s = 0; s < NS; s++) begin
          acc = 0;
          for (int s1 = 0; s1 < NS; s1++) acc += alpha[s1] * trans_tab[s1*NS + s];
          acc = acc >> FB;
          raw[s] = (acc * emit_tab[s*NY + r.symbol]) >> FB;
          sum += raw[s];
        end
        for (int s = 0; s < NS; s++) begin
          p = 0;
          if (sum != 0) begin
            p = (raw[s] << FB) / sum;
            if (p > ONE) p = ONE;
          end
          alpha[s] = p;
          e.state_index = RowW'(s);
          e.probability = ValueW'(p);
          e.scale = ValueW'((sum > ONE) ? ONE : sum);
          e.zero_scale = (sum == 0);
          e.last = (s == NS-1);
          // Override with the hand-computed values where the row gives them.
          if (r.typed) begin
            e.scale = r.t_scale;
            e.zero_scale = r.t_zero;
          end
          pending_filt.push_back(e);
        end
      end
    endcase
  endfunction

  // Drive one request after a random gap; hold until accepted.
  task automatic send(request_t r);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    row <= r.row;
    col <= r.col;
    value <= r.value;
    symbol <= r.symbol;
    do @(posedge clk); while (in_stall);
    filter_step(r);
  endtask

  function automatic request_t mk(kind_e k, int rw, int cl, int v, int sy);
    request_t r;
    r.kind = k; r.row = RowW'(rw); r.col = ColW'(cl); r.value = ValueW'(v);
    r.symbol = SymbolW'(sy);
    r.typed = 1'b0; r.t_scale = '0; r.t_zero = 1'b0;
    return r;
  endfunction

  function automatic request_t mk_typed(int sy, int sc, bit z);
    request_t r;
    r = mk(KIND_SYMBOL, 0, 0, 0, sy);
    r.typed = 1'b1; r.t_scale = ValueW'(sc); r.t_zero = z;
    return r;
  endfunction

  // Check results and draw receiver stalls.
  always @(posedge clk) begin
    filt_res_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{state_index, probability, scale, zero_scale, last};
        if (pending_filt.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_filt.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
        out_wait = out_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      end
      out_stall <= (out_wait != 0);
      if (out_wait != 0) out_wait--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    request_t r;
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both tables: uniform transitions (1/8), uniform emissions (1/16).
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NS; j++) send(mk(KIND_LOAD_TRANS, i, j, 8192, 0));
    for (int i = 0; i < NS; i++)
      for (int j = 0; j < NY; j++) send(mk(KIND_LOAD_EMIT, i, j, 4096, 0));

    // Directed: uniform step, zero emission column, sticky zero vector,
    // saturated loads, ignored out-of-range column, unnormalized tables.
    directed.push_back(mk(KIND_START, 0, 0, 0, 0));
    directed.push_back(mk_typed(0, 4096, 1'b0));
    for (int i = 0; i < NS; i++) directed.push_back(mk(KIND_LOAD_EMIT, i, 5, 0, 0));
    directed.push_back(mk_typed(5, 0, 1'b1));
    directed.push_back(mk_typed(0, 0, 1'b1));
    directed.push_back(mk(KIND_START, 0, 0, 0, 0));
    directed.push_back(mk_typed(0, 4096, 1'b0));
    directed.push_back(mk(KIND_LOAD_TRANS, 0, 0, 131071, 0));
    directed.push_back(mk(KIND_LOAD_TRANS, 2, 9, 0, 0));
    directed.push_back(mk(KIND_LOAD_EMIT, 0, 3, 65536, 0));
    directed.push_back(mk(KIND_LOAD_EMIT, 7, 15, 131071, 0));
    directed.push_back(mk(KIND_START, 0, 0, 0, 0));
    directed.push_back(mk(KIND_SYMBOL, 0, 0, 0, 3));
    directed.push_back(mk(KIND_SYMBOL, 0, 0, 0, 15));
    foreach (directed[i]) send(directed[i]);

    // Random: mostly symbols and restarts, with table rewrites mixed in.
    for (int n = 0; n < 110; n++) begin
      k = $urandom_range(0, 99);
      r = mk(KIND_SYMBOL, $urandom_range(0, 7), $urandom_range(0, 15),
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                         : $urandom_range(0, 65536),
             $urandom_range(0, 15));
      if (k < 15) r.kind = KIND_LOAD_TRANS;
      else if (k < 30) r.kind = KIND_LOAD_EMIT;
      else if (k < 45) r.kind = KIND_START;
      send(r);
    end
    in_valid <= 1'b0;

    while (pending_filt.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
